// ===== hw/rtl/crc16_framed_packet_checker_top_defines.svh =====
// Assertion macros used by the command queue of the frame checker RTL.
`ifndef CRC16_FRAMED_PACKET_CHECKER_TOP_DEFINES_SVH
`define CRC16_FRAMED_PACKET_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cfpc_pkg.sv =====
// Types, constants and the CRC function of the framed packet checker.
package cfpc_pkg;

	localparam int MAX_FRAME_BYTES = 1024;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES);
	localparam int LEN_W = 10;
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int HDR_BYTES = 4;
	localparam int CMD_QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(CMD_QUEUE_DEPTH);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(64);

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_SHORT = 2'd1,
		STATUS_CRC   = 2'd2,
		STATUS_LONG  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// One entry of the queue between the front and the back.
	typedef struct packed {
		logic                 has_payload;
		logic [7:0]           pbyte;
		logic                 is_last;
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [LEN_W-1:0]     plen;
		status_t              status;
	} cmd_t;

	// Bit-reflected CRC16-Modbus update by one byte.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/cfpc_front.sv =====
// Front end: frame state, CRC, header capture and per-byte classification.
module cfpc_front import cfpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	input  logic             last_byte,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data,
	output logic             cmd_push,
	output cmd_t             cmd,
	input  logic             q_full
);

	logic [15:0]          crc_q;
	logic [CNT_W-1:0]     count_q;
	logic                 overrun_q;
	logic [HDR_BYTES-1:0][7:0] hdr_q;
	logic [1:0][7:0]      dly_q;
	logic [LEN_W-1:0]     limit_q;

	logic                 accept;
	logic [15:0]          crc_next;
	logic                 upd;
	logic                 have_payload;
	logic                 too_short;
	logic [15:0]          rx_crc;
	logic [CNT_W-1:0]     p;
	status_t              verdict;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	assign crc_next     = crc16_byte(crc_q, dly_q[0]);
	assign upd          = count_q >= CNT_W'(2);
	assign have_payload = upd && ((count_q >= CNT_W'(6)) || overrun_q);
	assign too_short    = (count_q < CNT_W'(5)) && !overrun_q;
	assign rx_crc       = {in_byte, dly_q[1]};
	assign p            = count_q - CNT_W'(5);

	always_comb begin
		if (too_short) begin
			verdict = STATUS_SHORT;
		end else if (rx_crc != crc_next) begin
			verdict = STATUS_CRC;
		end else if (overrun_q || (CMP_W'(p) > CMP_W'(limit_q))) begin
			verdict = STATUS_LONG;
		end else begin
			verdict = STATUS_OK;
		end
	end

	always_comb begin
		cmd_push        = accept && (have_payload || last_byte);
		cmd.has_payload = have_payload;
		cmd.pbyte       = dly_q[0];
		cmd.is_last     = last_byte;
		cmd.hdr         = too_short ? '0 : hdr_q;
		cmd.plen        = (verdict == STATUS_OK) ? LEN_W'(p) : '0;
		cmd.status      = verdict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			count_q   <= '0;
			overrun_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				crc_q     <= CRC_INIT;
				count_q   <= '0;
				overrun_q <= 1'b0;
			end else begin
				if (upd) begin
					crc_q <= crc_next;
				end
				// The byte count sticks at its top value and flags the overrun instead.
				if (count_q < CNT_W'(MAX_FRAME_BYTES - 1)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					overrun_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q < CNT_W'(HDR_BYTES)) begin
				hdr_q[count_q[1:0]] <= in_byte;
			end
			dly_q[0] <= dly_q[1];
			dly_q[1] <= in_byte;
		end
	end

endmodule

// ===== hw/rtl/cfpc_cmd_fifo.sv =====
// Short command queue between the front end and the result back end.
`include "crc16_framed_packet_checker_top_defines.svh"
module cfpc_cmd_fifo import cfpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t              mem_q [CMD_QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(CMD_QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	`CFPC_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !full, "command pushed into a full queue")
	`CFPC_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !empty, "command popped from an empty queue")
	`CFPC_ASSERT_NEXT(a_count_track, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a transfer")

endmodule

// ===== hw/rtl/cfpc_back.sv =====
// Back end: expands queued commands into payload and verdict results.
module cfpc_back import cfpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic                 kind,
	output logic [7:0]           payload_byte,
	output logic [HDR_BYTES-1:0][7:0] hdr,
	output logic [LEN_W-1:0]     payload_length,
	output logic [1:0]           status,
	output logic                 end_of_run
);

	logic      out_valid_q;
	logic      phase_q;
	kind_t     kind_q;
	logic [7:0] pbyte_q;
	logic [HDR_BYTES-1:0][7:0] hdr_q;
	logic [LEN_W-1:0] plen_q;
	status_t   status_q;
	logic      eor_q;

	logic load;
	logic emit_payload;

	assign load         = (!out_valid_q || pop) && !q_empty;
	assign emit_payload = head.has_payload && !phase_q;
	// A last byte that also frees a payload byte keeps its command for a second result.
	assign q_pop        = load && !(emit_payload && head.is_last);

	assign empty          = !out_valid_q;
	assign kind           = kind_q;
	assign payload_byte   = pbyte_q;
	assign hdr            = hdr_q;
	assign payload_length = plen_q;
	assign status         = status_q;
	assign end_of_run     = eor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= emit_payload && head.is_last;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_payload) begin
				kind_q   <= KIND_PAYLOAD;
				pbyte_q  <= head.pbyte;
				hdr_q    <= '0;
				plen_q   <= '0;
				status_q <= STATUS_OK;
				eor_q    <= !head.is_last;
			end else begin
				kind_q   <= KIND_VERDICT;
				pbyte_q  <= '0;
				hdr_q    <= head.hdr;
				plen_q   <= head.plen;
				status_q <= head.status;
				eor_q    <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/crc16_framed_packet_checker_top.sv =====
// Top level of the CRC16 framed packet checker.
//
// Input side is a queue write port: a byte transfers on a clock edge with push
// high and full low; last_byte marks the final byte of a frame. Results come out
// of a queue read port: the oldest result is on the ports while empty is low and
// transfers on an edge with pop high. Each payload byte yields one payload result
// (kind 0) two bytes after it arrives; the final byte yields a verdict (kind 1)
// carrying the header, the payload length and the status.
// A byte is taken every cycle while full is low; the CRC update of one byte in
// the front end sets that rate. A result passes through the command queue and
// the output register to the ports; the verdict after a payload result from the
// same last byte is loaded from the same queue entry when that result is popped.
// A four-entry command queue and the output register absorb receiver stalls;
// full rises once all four queue entries are occupied, and nothing is dropped.
// The user writes the payload limit register over cfg_valid/cfg_ready (always
// ready) only while no frame result is pending; the block does not enforce this.
// Reset clears frame state, queue and output, and sets the payload limit to 64.
module crc16_framed_packet_checker_top import cfpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	input  logic             last_byte,
	output logic             empty,
	input  logic             pop,
	output logic             kind,
	output logic [7:0]       payload_byte,
	output logic [7:0]       dest_addr,
	output logic [7:0]       src_addr,
	output logic [7:0]       message_type,
	output logic [7:0]       sequence_number,
	output logic [LEN_W-1:0] payload_length,
	output logic [1:0]       status,
	output logic             end_of_run,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	logic cmd_push;
	cmd_t cmd_w;
	cmd_t cmd_r;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic [HDR_BYTES-1:0][7:0] hdr;

	cfpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_w),
		.q_full    (q_full)
	);

	cfpc_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_w),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (cmd_r),
		.empty  (q_empty)
	);

	cfpc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (cmd_r),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.hdr            (hdr),
		.payload_length (payload_length),
		.status         (status),
		.end_of_run     (end_of_run)
	);

	assign dest_addr       = hdr[0];
	assign src_addr        = hdr[1];
	assign message_type    = hdr[2];
	assign sequence_number = hdr[3];

endmodule
